[design/two_axis_goto_stepper_unit_assert.svh]
// assertion macros used by the checker file
`ifndef TWO_AXIS_GOTO_STEPPER_UNIT_ASSERT_SVH
`define TWO_AXIS_GOTO_STEPPER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TGS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("tgs check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("tgs check failed");

`endif

[design/tgs_pkg.sv]
// types and constants of the two-axis goto stepper
`timescale 1ns / 1ps

package tgs_pkg;

	localparam int RATE_W    = 20;
	localparam int POS_W     = 20;
	localparam int FUNC_W    = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [RATE_W-1:0] RATE_RESET = 20'd5825;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK       = 3'd0,
		FUNC_GOTO       = 3'd1,
		FUNC_MOVE_WRAP  = 3'd2,
		FUNC_MOVE_LIMIT = 3'd3,
		FUNC_ABORT      = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_SLEW    = 2'd1,
		MODE_SLEW_TO = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WRAP_RATE  = 2'd0,
		REG_LIMIT_RATE = 2'd1
	} reg_idx_t;

	// decoded command for one axis, at most one of tick/go/move/abort set
	typedef struct packed {
		logic tick;
		logic go;
		logic move;
		logic abort;
		logic fwd;
		logic start;
	} axis_cmd_t;

endpackage

[design/tgs_rate_reg.sv]
// steps-per-tick register with its reduced step modulo one revolution
`timescale 1ns / 1ps

module tgs_rate_reg import tgs_pkg::*; #(
	parameter int REV = 1048576
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [RATE_W-1:0] data,
	output logic [RATE_W-1:0] rate,
	output logic [RATE_W-1:0] step,
	output logic              full,
	output logic              settling
);

	localparam int SHIFT = 40;
	localparam longint unsigned RECIP = (64'd1 << SHIFT) / REV;
	localparam int RCP_W = $clog2(RECIP + 1);
	localparam logic [RCP_W-1:0] RECIP_K = RCP_W'(RECIP);
	localparam logic [31:0] REV_U = 32'(REV);
	localparam logic [RATE_W-1:0] QUO_RESET = RATE_W'(RATE_RESET / REV);
	localparam logic [RATE_W-1:0] STEP_RESET = RATE_W'(RATE_RESET % REV);
	localparam logic FULL_RESET = (32'(RATE_RESET) >= REV_U);

	logic [RATE_W+RCP_W-1:0] prod;
	logic [RATE_W-1:0] quo_est, back, rem, step_d;
	logic [RATE_W-1:0] rate_q, quo_q, step_q;
	logic full_q, settle_q;

	// quotient estimate by reciprocal, low by at most one
	assign prod    = data * RECIP_K;
	assign quo_est = RATE_W'(prod >> SHIFT);

	assign back   = RATE_W'(32'(quo_q) * REV_U);
	assign rem    = rate_q - back;
	assign step_d = (32'(rem) >= REV_U) ? rem - RATE_W'(REV_U) : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RATE_RESET;
			quo_q    <= QUO_RESET;
			full_q   <= FULL_RESET;
			step_q   <= STEP_RESET;
			settle_q <= 1'b0;
		end else begin
			if (we) begin
				rate_q <= data;
				quo_q  <= quo_est;
				full_q <= (32'(data) >= REV_U);
			end
			step_q   <= step_d;
			settle_q <= we;
		end
	end

	assign rate     = rate_q;
	assign step     = step_q;
	assign full     = full_q;
	assign settling = settle_q;

endmodule

[design/tgs_wrap_axis.sv]
// wrapping axis state and its per-item update
`timescale 1ns / 1ps

module tgs_wrap_axis import tgs_pkg::*; #(
	parameter int REV = 1048576
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  axis_cmd_t         cmd,
	input  logic [POS_W-1:0]  target,
	input  logic [RATE_W-1:0] step,
	input  logic              full,
	output logic              in_range,
	output logic [POS_W-1:0]  position,
	output mode_t             mode
);

	localparam int WPW = $clog2(REV);
	localparam logic [WPW:0] REV_X = (WPW + 1)'(REV);
	localparam int XW = (WPW > POS_W) ? WPW : POS_W;

	logic [WPW-1:0] pos_q, tgt_q, pos_d, tgt_d;
	logic [WPW-1:0] tw, st, fwd_np, rev_np, np, diff_up, diff_dn;
	logic [WPW:0] sum, wrapped;
	logic [XW-1:0] pos_x;
	mode_t mode_q, mode_d;
	logic fwd_q, fwd_d, hit, goto_fwd;

	assign in_range = (32'(target) < 32'(REV));
	assign tw = WPW'(target);
	assign st = WPW'(step);

	assign sum     = {1'b0, pos_q} + {1'b0, st};
	assign fwd_np  = (sum >= REV_X) ? WPW'(sum - REV_X) : WPW'(sum);
	assign wrapped = {1'b0, pos_q} + REV_X - {1'b0, st};
	assign rev_np  = (pos_q >= st) ? pos_q - st : WPW'(wrapped);
	assign np      = fwd_q ? fwd_np : rev_np;

	// target inside the swept span, wrapped span included
	always_comb begin
		if (full) begin
			hit = 1'b1;
		end else if (fwd_q) begin
			if (np < pos_q)
				hit = (tgt_q >= pos_q) || (tgt_q <= np);
			else
				hit = (tgt_q >= pos_q) && (tgt_q <= np);
		end else begin
			if (np > pos_q)
				hit = (tgt_q <= pos_q) || (tgt_q >= np);
			else
				hit = (tgt_q >= np) && (tgt_q <= pos_q);
		end
	end

	// shortest way round, half-revolution tie takes the way through zero
	assign diff_up  = tw - pos_q;
	assign diff_dn  = pos_q - tw;
	assign goto_fwd = (tw > pos_q) ? ({diff_up, 1'b0} < REV_X) : !({diff_dn, 1'b0} < REV_X);

	always_comb begin
		pos_d  = pos_q;
		tgt_d  = tgt_q;
		fwd_d  = fwd_q;
		mode_d = mode_q;
		if (cmd.tick) begin
			if (mode_q == MODE_SLEW || mode_q == MODE_SLEW_TO) begin
				pos_d = np;
				if (mode_q == MODE_SLEW_TO && hit) begin
					mode_d = MODE_STOPPED;
					pos_d  = tgt_q;
				end
			end
		end else if (cmd.go) begin
			tgt_d = tw;
			if (tw == pos_q) begin
				mode_d = MODE_STOPPED;
			end else begin
				fwd_d  = goto_fwd;
				mode_d = MODE_SLEW_TO;
			end
		end else if (cmd.move) begin
			fwd_d  = cmd.fwd;
			mode_d = cmd.start ? MODE_SLEW : MODE_STOPPED;
		end else if (cmd.abort) begin
			mode_d = MODE_STOPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tgt_q  <= '0;
			fwd_q  <= 1'b1;
			mode_q <= MODE_STOPPED;
		end else if (upd) begin
			pos_q  <= pos_d;
			tgt_q  <= tgt_d;
			fwd_q  <= fwd_d;
			mode_q <= mode_d;
		end
	end

	assign pos_x    = XW'(pos_d);
	assign position = pos_x[POS_W-1:0];
	assign mode     = mode_d;

endmodule

[design/tgs_limit_axis.sv]
// limited axis state and its per-item update
`timescale 1ns / 1ps

module tgs_limit_axis import tgs_pkg::*; #(
	parameter int LIM = 262144
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     upd,
	input  axis_cmd_t                cmd,
	input  logic signed [POS_W-1:0]  target,
	input  logic [RATE_W-1:0]        rate,
	input  logic [RATE_W-1:0]        step,
	output logic                     in_range,
	output logic signed [POS_W-1:0]  position,
	output mode_t                    mode
);

	localparam int LPW = $clog2(LIM + 1) + 1;
	localparam int LNW = ((LPW > RATE_W + 1) ? LPW : RATE_W + 1) + 1;
	localparam int TCW = ((LPW > POS_W) ? LPW : POS_W) + 1;
	localparam int OXW = (LPW > POS_W) ? LPW : POS_W;
	localparam logic signed [TCW-1:0] LIM_T = TCW'(LIM);
	localparam logic signed [LNW-1:0] LIM_N = LNW'(LIM);

	logic signed [LPW-1:0] pos_q, tgt_q, pos_d, tgt_d, tl;
	logic signed [TCW-1:0] t_x;
	logic signed [LNW-1:0] pos_w, tgt_w, delta, absd, rate_w, step_w, s_w, np;
	logic signed [OXW-1:0] pos_x;
	mode_t mode_q, mode_d;
	logic fwd_q, fwd_d;

	assign t_x      = TCW'(target);
	assign in_range = (t_x <= LIM_T) && (t_x >= -LIM_T);
	assign tl       = LPW'(target);

	assign pos_w  = LNW'(pos_q);
	assign tgt_w  = LNW'(tgt_q);
	assign rate_w = $signed(LNW'(rate));
	assign step_w = $signed(LNW'(step));
	assign delta  = pos_w - tgt_w;
	assign absd   = delta[LNW-1] ? -delta : delta;

	// jogging uses the reduced step, a goto the raw rate
	assign s_w = (mode_q == MODE_SLEW) ? step_w : rate_w;
	assign np  = fwd_q ? pos_w + s_w : pos_w - s_w;

	always_comb begin
		pos_d  = pos_q;
		tgt_d  = tgt_q;
		fwd_d  = fwd_q;
		mode_d = mode_q;
		if (cmd.tick) begin
			if (mode_q == MODE_SLEW_TO && absd <= rate_w) begin
				mode_d = MODE_STOPPED;
				pos_d  = tgt_q;
			end else if (mode_q == MODE_SLEW || mode_q == MODE_SLEW_TO) begin
				if (np > LIM_N) begin
					pos_d  = LPW'(LIM_N);
					mode_d = MODE_STOPPED;
				end else if (np < -LIM_N) begin
					pos_d  = LPW'(-LIM_N);
					mode_d = MODE_STOPPED;
				end else begin
					pos_d = LPW'(np);
				end
			end
		end else if (cmd.go) begin
			tgt_d = tl;
			if (tl == pos_q) begin
				mode_d = MODE_STOPPED;
			end else begin
				fwd_d  = (tl > pos_q);
				mode_d = MODE_SLEW_TO;
			end
		end else if (cmd.move) begin
			fwd_d  = cmd.fwd;
			mode_d = cmd.start ? MODE_SLEW : MODE_STOPPED;
		end else if (cmd.abort) begin
			mode_d = MODE_STOPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tgt_q  <= '0;
			fwd_q  <= 1'b1;
			mode_q <= MODE_STOPPED;
		end else if (upd) begin
			pos_q  <= pos_d;
			tgt_q  <= tgt_d;
			fwd_q  <= fwd_d;
			mode_q <= mode_d;
		end
	end

	assign pos_x    = OXW'(pos_d);
	assign position = pos_x[POS_W-1:0];
	assign mode     = mode_d;

endmodule

[design/two_axis_goto_stepper_unit.sv]
// top level of the two-axis goto stepper
//
// channel  handshake              payload
// cfg      cfg_we                 cfg_index, cfg_data
// in       in_valid / in_ready    func, target_wrap_steps, target_limit_steps,
//                                 move_forward, move_start
// out      out_valid / out_ready  wrap_position, limit_position, wrap_status,
//                                 limit_status, goto_busy, goto_ok
//
// one item per cycle while no step settles and the output is taken; items pass the input
// then result register; each axis updates from its own state registers, setting that rate
// reset: both axes stopped at position zero, heading forward, both rates back to 5825
// a register write holds the next item back while the reduced step settles
// in_ready drops only when the input register is full and its result cannot move on
`timescale 1ns / 1ps

module two_axis_goto_stepper_unit import tgs_pkg::*; #(
	parameter int STEPS_PER_REV = 1048576,
	parameter int LIMIT_STEPS   = 262144
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration writes
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [RATE_W-1:0]        cfg_data,
	// command items
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [FUNC_W-1:0]        func,
	input  logic [POS_W-1:0]         target_wrap_steps,
	input  logic signed [POS_W-1:0]  target_limit_steps,
	input  logic                     move_forward,
	input  logic                     move_start,
	// result items
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [POS_W-1:0]         wrap_position,
	output logic signed [POS_W-1:0]  limit_position,
	output logic [1:0]               wrap_status,
	output logic [1:0]               limit_status,
	output logic                     goto_busy,
	output logic                     goto_ok
);

	// input register
	logic                    valid_s1;
	logic [FUNC_W-1:0]       func_s1;
	logic [POS_W-1:0]        tw_s1;
	logic signed [POS_W-1:0] tl_s1;
	logic                    fwd_s1;
	logic                    start_s1;

	// result register
	logic                    out_valid_q;
	logic [POS_W-1:0]        wrap_pos_q;
	logic signed [POS_W-1:0] limit_pos_q;
	mode_t                   wrap_mode_q;
	mode_t                   limit_mode_q;
	logic                    busy_out_q;
	logic                    ok_q;

	// goto in progress
	logic busy_q, busy_d;

	// rate registers
	logic [RATE_W-1:0] wrap_rate, wrap_step, limit_rate, limit_step;
	logic wrap_full, limit_full, wrap_settle, limit_settle;
	logic wrap_we, limit_we;

	// axis update
	axis_cmd_t wrap_cmd, limit_cmd;
	logic wrap_ok, limit_ok, goto_ok_d;
	logic is_tick, is_goto, is_abort, is_move_wrap, is_move_limit;
	logic [POS_W-1:0] wrap_pos_d;
	logic signed [POS_W-1:0] limit_pos_d;
	mode_t wrap_mode_d, limit_mode_d;

	logic advance;

	// item executes when the result register is free or draining, and no step is settling
	assign advance  = valid_s1 && !wrap_settle && !limit_settle && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1  <= func;
			tw_s1    <= target_wrap_steps;
			tl_s1    <= target_limit_steps;
			fwd_s1   <= move_forward;
			start_s1 <= move_start;
		end
	end

	// register writes, unknown indexes dropped
	assign wrap_we  = cfg_we && (cfg_index == REG_WRAP_RATE);
	assign limit_we = cfg_we && (cfg_index == REG_LIMIT_RATE);

	tgs_rate_reg #(
		.REV(STEPS_PER_REV)
	) u_wrap_rate (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (wrap_we),
		.data     (cfg_data),
		.rate     (wrap_rate),
		.step     (wrap_step),
		.full     (wrap_full),
		.settling (wrap_settle)
	);

	tgs_rate_reg #(
		.REV(STEPS_PER_REV)
	) u_limit_rate (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (limit_we),
		.data     (cfg_data),
		.rate     (limit_rate),
		.step     (limit_step),
		.full     (limit_full),
		.settling (limit_settle)
	);

	// command decode, codes five to seven leave everything alone
	always_comb begin
		is_tick       = 1'b0;
		is_goto       = 1'b0;
		is_move_wrap  = 1'b0;
		is_move_limit = 1'b0;
		is_abort      = 1'b0;
		case (func_s1)
			FUNC_TICK:       is_tick       = 1'b1;
			FUNC_GOTO:       is_goto       = 1'b1;
			FUNC_MOVE_WRAP:  is_move_wrap  = 1'b1;
			FUNC_MOVE_LIMIT: is_move_limit = 1'b1;
			FUNC_ABORT:      is_abort      = 1'b1;
			default:         is_tick       = 1'b0;
		endcase
	end

	// a goto is taken only when both targets are in range
	assign goto_ok_d = is_goto && wrap_ok && limit_ok;

	always_comb begin
		wrap_cmd.tick   = is_tick;
		wrap_cmd.go     = goto_ok_d;
		wrap_cmd.move   = is_move_wrap;
		wrap_cmd.abort  = is_abort;
		wrap_cmd.fwd    = fwd_s1;
		wrap_cmd.start  = start_s1;
		limit_cmd.tick  = is_tick;
		limit_cmd.go    = goto_ok_d;
		limit_cmd.move  = is_move_limit;
		limit_cmd.abort = is_abort;
		limit_cmd.fwd   = fwd_s1;
		limit_cmd.start = start_s1;
	end

	tgs_wrap_axis #(
		.REV(STEPS_PER_REV)
	) u_wrap_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (advance),
		.cmd      (wrap_cmd),
		.target   (tw_s1),
		.step     (wrap_step),
		.full     (wrap_full),
		.in_range (wrap_ok),
		.position (wrap_pos_d),
		.mode     (wrap_mode_d)
	);

	tgs_limit_axis #(
		.LIM(LIMIT_STEPS)
	) u_limit_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (advance),
		.cmd      (limit_cmd),
		.target   (tl_s1),
		.rate     (limit_rate),
		.step     (limit_step),
		.in_range (limit_ok),
		.position (limit_pos_d),
		.mode     (limit_mode_d)
	);

	// busy flag: set by an accepted goto, dropped by abort or a tick that leaves both stopped
	always_comb begin
		busy_d = busy_q;
		if (is_tick && wrap_mode_d == MODE_STOPPED && limit_mode_d == MODE_STOPPED)
			busy_d = 1'b0;
		else if (goto_ok_d)
			busy_d = 1'b1;
		else if (is_abort)
			busy_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				busy_q <= busy_d;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload, held while the transfer is stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			wrap_pos_q   <= wrap_pos_d;
			limit_pos_q  <= limit_pos_d;
			wrap_mode_q  <= wrap_mode_d;
			limit_mode_q <= limit_mode_d;
			busy_out_q   <= busy_d;
			ok_q         <= goto_ok_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign wrap_position  = wrap_pos_q;
	assign limit_position = limit_pos_q;
	assign wrap_status    = wrap_mode_q;
	assign limit_status   = limit_mode_q;
	assign goto_busy      = busy_out_q;
	assign goto_ok        = ok_q;

endmodule

[design/tgs_checker.sv]
// port-level checks of the two-axis goto stepper, bound to the top level
`timescale 1ns / 1ps
`include "two_axis_goto_stepper_unit_assert.svh"

module tgs_checker import tgs_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [POS_W-1:0]         wrap_position,
	input logic signed [POS_W-1:0]  limit_position,
	input logic [1:0]               wrap_status,
	input logic [1:0]               limit_status,
	input logic                     goto_busy,
	input logic                     goto_ok
);

	// a stalled result keeps its payload
	`TGS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(wrap_position) && $stable(limit_position) && $stable(goto_busy))

	// an accepted goto always leaves the busy flag up
	`TGS_ASSERT_SAME(a_ok_busy, out_valid && goto_ok, goto_busy)

	// an accepted goto never leaves an axis jogging
	`TGS_ASSERT_SAME(a_ok_no_jog, out_valid && goto_ok, (wrap_status != MODE_SLEW) && (limit_status != MODE_SLEW))

	// an axis heading for a target implies a goto in progress
	`TGS_ASSERT_SAME(a_slew_to_busy, out_valid && ((wrap_status == MODE_SLEW_TO) || (limit_status == MODE_SLEW_TO)), goto_busy)

endmodule

bind two_axis_goto_stepper_unit tgs_checker u_tgs_checker (.*);
